// File: hdl/xsfb_pkg.sv
`timescale 1ns / 1ps

package xsfb_pkg;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 64;
    localparam int BYTES_PER_ROW = MAX_WIDTH / 8;
    localparam int STORE_DEPTH   = BYTES_PER_ROW * MAX_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int WB_W          = 5;
    localparam int BX_W          = 4;
    localparam int H_W           = 7;
    localparam int Y_W           = 6;
    localparam int DVD_W         = 8;
    localparam int CNT_W         = $clog2(DVD_W);
    localparam int PADDR_W       = 3;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0]     FRAME_WIDTH_RST  = 8'd64;
    localparam logic [H_W-1:0] FRAME_HEIGHT_RST = 7'd32;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XMOD,
        ST_YMOD,
        ST_ADDR,
        ST_RD0,
        ST_MOD0,
        ST_RD1,
        ST_MOD1,
        ST_STEP,
        ST_OUT
    } state_t;

    // bytes per frame row, limited to 1 .. BYTES_PER_ROW
    function automatic logic [WB_W-1:0] eff_wb(input logic [7:0] fw);
        logic [WB_W-1:0] wb;
        wb = fw[7:3];
        if (wb == '0)
        begin
            wb = WB_W'(1);
        end
        else if (wb > WB_W'(BYTES_PER_ROW))
        begin
            wb = WB_W'(BYTES_PER_ROW);
        end
        return wb;
    endfunction

    // frame height, limited to 1 .. MAX_HEIGHT
    function automatic logic [H_W-1:0] eff_h(input logic [H_W-1:0] fh);
        logic [H_W-1:0] h;
        h = fh;
        if (h == '0)
        begin
            h = H_W'(1);
        end
        else if (h > H_W'(MAX_HEIGHT))
        begin
            h = H_W'(MAX_HEIGHT);
        end
        return h;
    endfunction

endpackage

// File: hdl/xor_sprite_frame_buffer_core.sv
`timescale 1ns / 1ps
// draw and read words run two 8-step remainder passes on the shared compare-subtract unit;
// then up to two byte read-modify-writes (draw) or one byte read (read) on the single ram port
// one word at a time; in_ready is low until the word is done and any result is in the output register
// clear walks the 1024-byte store one byte per cycle (no input taken meanwhile)
// after rst_n the same clearing pass runs before in_ready first rises
// rst_n is asynchronous active low; sizes return to 64 x 32
module xor_sprite_frame_buffer_core
    import xsfb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         x_origin,
    input  logic [7:0]         y_origin,
    input  logic [7:0]         sprite_row,
    input  logic               last_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic               collision,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    state_t state_reg, state_next;

    logic [7:0]        fw_reg;
    logic [H_W-1:0]    fh_reg;
    logic [WB_W-1:0]   wb;
    logic [H_W-1:0]    h;

    logic [1:0]        cmd_reg, cmd_next;
    logic [2:0]        sh_reg, sh_next;
    logic [7:0]        yo_reg, yo_next;
    logic [7:0]        spr_reg, spr_next;
    logic              last_reg, last_next;
    logic [BX_W-1:0]   bx_reg, bx_next;
    logic [Y_W-1:0]    y0_reg, y0_next;
    logic [Y_W-1:0]    row_count_reg, row_count_next;
    logic              acc_reg, acc_next;
    logic              hit_reg, hit_next;
    logic              second_reg, second_next;
    logic [ADDR_W-1:0] addr0_reg, addr0_next;
    logic [7:0]        bits0_reg, bits0_next;
    logic [7:0]        bits1_reg, bits1_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        read_data_reg, read_data_next;
    logic              collision_reg, collision_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_coll_reg, res_coll_next;

    logic              accept;
    logic              mod_start;
    logic [DVD_W-1:0]  mod_dividend;
    logic [H_W-1:0]    mod_divisor;
    logic              mod_done;
    logic [Y_W-1:0]    mod_rem;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic [H_W-1:0]    y_sum;
    logic [ADDR_W:0]   idx;
    logic [15:0]       shifted;
    logic              coll;
    logic              cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[PADDR_W-1] == REG_FRAME_HEIGHT)
            begin
                fh_reg <= pwdata[H_W-1:0];
            end
            else
            begin
                fw_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_FRAME_WIDTH) ? {24'd0, fw_reg}
                                                          : {25'd0, fh_reg};

    assign wb = eff_wb(fw_reg);
    assign h  = eff_h(fh_reg);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // shared remainder unit: byte column first, then row
    assign mod_start = (accept && (cmd == CMD_DRAW || cmd == CMD_READ))
                    || (state_reg == ST_XMOD && mod_done);
    assign mod_dividend = (state_reg == ST_IDLE) ? {3'd0, x_origin[7:3]} : yo_reg;
    assign mod_divisor  = (state_reg == ST_IDLE) ? {2'd0, wb} : h;

    xsfb_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    xsfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        y_sum   = {1'b0, y0_reg} + ((cmd_reg == CMD_DRAW) ? {1'b0, row_count_reg} : '0);
        idx     = (ADDR_W + 1)'(y_sum[Y_W-1:0]) * (ADDR_W + 1)'(wb)
                + (ADDR_W + 1)'(bx_reg);
        shifted = {spr_reg, 8'h00} >> sh_reg;
        coll    = acc_reg || hit_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sh_next        = sh_reg;
        yo_next        = yo_reg;
        spr_next       = spr_reg;
        last_next      = last_reg;
        bx_next        = bx_reg;
        y0_next        = y0_reg;
        row_count_next = row_count_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        second_next    = second_reg;
        addr0_next     = addr0_reg;
        bits0_next     = bits0_reg;
        bits1_next     = bits1_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_data_next  = res_data_reg;
        res_coll_next  = res_coll_reg;
        read_data_next = read_data_reg;
        collision_next = collision_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_addr       = addr0_reg;
        ram_wdata      = 8'd0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    sh_next   = x_origin[2:0];
                    yo_next   = y_origin;
                    spr_next  = sprite_row;
                    last_next = last_row;
                    if (cmd == CMD_CLEAR)
                    begin
                        row_count_next = '0;
                        acc_next       = 1'b0;
                        clr_cnt_next   = '0;
                        state_next     = ST_CLEAR;
                    end
                    else if (cmd == CMD_DRAW || cmd == CMD_READ)
                    begin
                        state_next = ST_XMOD;
                    end
                end
            end
            ST_XMOD:
            begin
                if (mod_done)
                begin
                    bx_next    = mod_rem[BX_W-1:0];
                    state_next = ST_YMOD;
                end
            end
            ST_YMOD:
            begin
                if (mod_done)
                begin
                    y0_next    = mod_rem;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                addr0_next  = idx[ADDR_W-1:0];
                second_next = (sh_reg != 3'd0) && ((WB_W'(bx_reg) + 1'b1) < wb);
                bits0_next  = shifted[15:8];
                bits1_next  = shifted[7:0];
                hit_next    = 1'b0;
                state_next  = (y_sum < h) ? ST_RD0 : ST_STEP;
            end
            ST_RD0:
            begin
                state_next = ST_MOD0;
            end
            ST_MOD0:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    res_data_next = ram_rdata;
                    res_coll_next = 1'b0;
                    state_next    = ST_OUT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata ^ bits0_reg;
                    hit_next   = |(ram_rdata & bits0_reg);
                    state_next = second_reg ? ST_RD1 : ST_STEP;
                end
            end
            ST_RD1:
            begin
                ram_addr   = addr0_reg + 1'b1;
                state_next = ST_MOD1;
            end
            ST_MOD1:
            begin
                ram_we     = 1'b1;
                ram_addr   = addr0_reg + 1'b1;
                ram_wdata  = ram_rdata ^ bits1_reg;
                hit_next   = hit_reg || (|(ram_rdata & bits1_reg));
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (last_reg)
                begin
                    res_data_next  = 8'd0;
                    res_coll_next  = coll;
                    row_count_next = '0;
                    acc_next       = 1'b0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                    acc_next       = coll;
                    state_next     = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    read_data_next = res_data_reg;
                    collision_next = res_coll_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            row_count_reg <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            row_count_reg <= row_count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        sh_reg        <= sh_next;
        yo_reg        <= yo_next;
        spr_reg       <= spr_next;
        last_reg      <= last_next;
        bx_reg        <= bx_next;
        y0_reg        <= y0_next;
        hit_reg       <= hit_next;
        second_reg    <= second_next;
        addr0_reg     <= addr0_next;
        bits0_reg     <= bits0_next;
        bits1_reg     <= bits1_next;
        res_data_reg  <= res_data_next;
        res_coll_reg  <= res_coll_next;
        read_data_reg <= read_data_next;
        collision_reg <= collision_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign collision = collision_reg;

    // clear word starts the sweep, so nothing is taken on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_CLEAR) |=> (!in_ready && clr_cnt_reg == '0))
        else $error("clear did not start a store sweep");

    // the last row of a sprite rewinds the row counter and collision flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && last_reg) |=> (row_count_reg == '0 && !acc_reg))
        else $error("sprite state not reset after last row");

    // a result word never carries both read data and a collision
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(collision_reg && read_data_reg != 8'd0))
        else $error("result word mixes read data and collision");

    // the second byte of a row is only touched when the first one was
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD1) |-> ($past(state_reg) == ST_MOD0 && second_reg))
        else $error("second byte accessed without first");

endmodule

// File: hdl/xsfb_ram.sv
`timescale 1ns / 1ps

module xsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/xsfb_mod.sv
`timescale 1ns / 1ps

module xsfb_mod
    import xsfb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [H_W-1:0]   divisor,
    output logic             done,
    output logic [Y_W-1:0]   remainder
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [H_W-1:0]   dvs_reg;
    logic [Y_W-1:0]   rem_reg;
    logic [Y_W-1:0]   rem_next;
    logic [H_W-1:0]   trial;

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        if (trial >= dvs_reg)
        begin
            rem_next = Y_W'(trial - dvs_reg);
        end
        else
        begin
            rem_next = trial[Y_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
